@@ rtl/aoct_pkg.sv @@
`timescale 1ns / 1ps
// Package for the address occurrence counting table.
// Holds field widths, parameter defaults and shared types; depends on nothing.
package aoct_pkg;

   localparam int ADDR_W         = 32;
   localparam int OUT_COUNT_W    = 16;
   localparam int TOTAL_W        = 11;
   localparam int BUCKETS_DEF    = 256;
   localparam int WAYS_DEF       = 4;
   localparam int COUNT_BITS_DEF = 16;

   // Outcome of examining one way of a bucket.
   typedef struct packed {
      logic hit;
      logic empty;
   } way_flags_type;

endpackage

@@ rtl/aoct_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on aoct_pkg for the payload widths.
interface aoct_req_if;
   logic                       valid;
   logic                       ready;
   logic [aoct_pkg::ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface aoct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found_before;
   logic [aoct_pkg::OUT_COUNT_W-1:0] occurrence_count;
   logic [aoct_pkg::TOTAL_W-1:0]     distinct_total;
   logic                            dropped;

   modport source (output valid, output found_before, output occurrence_count,
                   output distinct_total, output dropped, input ready);
   modport sink   (input valid, input found_before, input occurrence_count,
                   input distinct_total, input dropped, output ready);
endinterface

@@ rtl/aoct_bucket_ram.sv @@
`timescale 1ns / 1ps
// Bucket memory: one wide word per bucket holding all of its ways.
// One write port and one registered read port; no dependencies.
module aoct_bucket_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 196
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/aoct_way_unit.sv @@
`timescale 1ns / 1ps
// Shared way unit: compares one stored slot with the key and forms the
// saturated next count. Depends on aoct_pkg.
module aoct_way_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic [aoct_pkg::ADDR_W+COUNT_BITS:0] slot,
   input  logic [aoct_pkg::ADDR_W-1:0]          key,
   output aoct_pkg::way_flags_type              flags,
   output logic [COUNT_BITS-1:0]                count_next
);

   localparam int AW = aoct_pkg::ADDR_W;

   logic                  slot_valid;
   logic [AW-1:0]         slot_addr;
   logic [COUNT_BITS-1:0] slot_count;

   // Slot layout: valid in bit 0, then the address, then the count.
   assign slot_valid = slot[0];
   assign slot_addr  = slot[AW:1];
   assign slot_count = slot[AW+COUNT_BITS:AW+1];

   assign flags.hit   = slot_valid && (slot_addr == key);
   assign flags.empty = !slot_valid;
   assign count_next  = (&slot_count) ? slot_count : slot_count + COUNT_BITS'(1);

endmodule

@@ rtl/address_occurrence_counting_table.sv @@
`timescale 1ns / 1ps
// Top level of the address occurrence counting table: sequencer, counters
// and result register. Depends on aoct_pkg, aoct_if, aoct_bucket_ram, aoct_way_unit.
//
//   Port group   Direction  Contents
//   req_ch       in         valid, ready, address
//   rsp_ch       out        valid, ready, found_before, occurrence_count,
//                           distinct_total, dropped
//   csr_wr_*     in         write enable and count_start value
//
// An item passes from acceptance through one bucket read, a scan of the ways
// one a cycle through the shared compare unit, which stops early when the
// address hits, and, unless it is dropped, a write back to its result; the next
// item is taken in the cycle after the result has been accepted. After reset a
// clearing pass zeroes every bucket of the memory in turn; no item is accepted
// meanwhile, while register writes are taken at any time. A stalled response
// holds its item.
module address_occurrence_counting_table #(
   parameter int BUCKETS    = aoct_pkg::BUCKETS_DEF,
   parameter int WAYS       = aoct_pkg::WAYS_DEF,
   parameter int COUNT_BITS = aoct_pkg::COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   aoct_req_if.sink       req_ch,
   aoct_rsp_if.source     rsp_ch,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);

   localparam int AW     = aoct_pkg::ADDR_W;
   localparam int OW     = aoct_pkg::OUT_COUNT_W;
   localparam int TW     = aoct_pkg::TOTAL_W;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_W = 1 + AW + COUNT_BITS;
   localparam int WORD_W = WAYS * SLOT_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [BKT_W-1:0]      clr_ff, clr_in;
   logic [WAY_W-1:0]      way_ff, way_in;
   logic                  hit_ff, hit_in;
   logic                  free_ff, free_in;
   logic [WAY_W-1:0]      hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]      free_way_ff, free_way_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TW-1:0]         total_ff, total_in;
   logic                  cstart_ff, cstart_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic                  found_ff, found_in;
   logic [OW-1:0]         ocount_ff, ocount_in;
   logic [TW-1:0]         dtotal_ff, dtotal_in;
   logic                  drop_ff, drop_in;

   logic                    req_fire;
   logic                    mem_wr_en;
   logic [BKT_W-1:0]        mem_wr_addr;
   logic [WORD_W-1:0]       mem_wr_data;
   logic [WORD_W-1:0]       mem_rd_data;
   logic [SLOT_W-1:0]       cur_slot;
   aoct_pkg::way_flags_type flags;
   logic [COUNT_BITS-1:0]   count_next;
   logic [COUNT_BITS-1:0]   count_sel;
   logic [OW-1:0]           count_out;
   logic [WORD_W-1:0]       word_upd;

   aoct_bucket_ram #(
      .DEPTH (BUCKETS),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_ch.address[BKT_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign cur_slot = word_ff[way_ff*SLOT_W +: SLOT_W];

   aoct_way_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_way (
      .slot       (cur_slot),
      .key        (addr_ff),
      .flags      (flags),
      .count_next (count_next)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // The count reported for the item, limited to the output field width.
   assign count_sel = hit_ff  ? cnt_ff :
                      free_ff ? COUNT_BITS'(cstart_ff) : '0;

   generate
      if (COUNT_BITS > OW) begin : g_count_sat
         assign count_out = (|count_sel[COUNT_BITS-1:OW]) ? {OW{1'b1}} : count_sel[OW-1:0];
      end else begin : g_count_ext
         assign count_out = OW'(count_sel);
      end
   endgenerate

   always_comb begin
      word_upd = word_ff;
      if (hit_ff) begin
         word_upd[hit_way_ff*SLOT_W + AW + 1 +: COUNT_BITS] = cnt_ff;
      end else if (free_ff) begin
         word_upd[free_way_ff*SLOT_W +: SLOT_W] = {COUNT_BITS'(cstart_ff), addr_ff, 1'b1};
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      way_in      = way_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      hit_way_in  = hit_way_ff;
      free_way_in = free_way_ff;
      cnt_in      = cnt_ff;
      total_in    = total_ff;
      cstart_in   = csr_wr_en ? csr_wr_data : cstart_ff;
      addr_in     = addr_ff;
      word_in     = word_ff;
      found_in    = found_ff;
      ocount_in   = ocount_ff;
      dtotal_in   = dtotal_ff;
      drop_in     = drop_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff[BKT_W-1:0];
      mem_wr_data = word_upd;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               addr_in  = req_ch.address;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            word_in  = mem_rd_data;
            way_in   = '0;
            hit_in   = 1'b0;
            free_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            way_in = way_ff + WAY_W'(1);
            if (flags.hit) begin
               hit_in     = 1'b1;
               hit_way_in = way_ff;
               cnt_in     = count_next;
               state_in   = ST_UPDATE;
            end else begin
               // Remember only the first free way of the bucket.
               if (flags.empty && !free_ff) begin
                  free_in     = 1'b1;
                  free_way_in = way_ff;
               end
               if (way_ff == WAY_W'(WAYS - 1)) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            mem_wr_en = hit_ff || free_ff;
            if (!hit_ff && free_ff && !(&total_ff)) begin
               total_in  = total_ff + TW'(1);
               dtotal_in = total_ff + TW'(1);
            end else begin
               dtotal_in = total_ff;
            end
            found_in  = hit_ff;
            drop_in   = !hit_ff && !free_ff;
            ocount_in = count_out;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         total_ff  <= '0;
         cstart_ff <= 1'b1;
         way_ff    <= '0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         total_ff  <= total_in;
         cstart_ff <= cstart_in;
         way_ff    <= way_in;
         hit_ff    <= hit_in;
         free_ff   <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff  <= hit_way_in;
      free_way_ff <= free_way_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      word_ff     <= word_in;
      found_ff    <= found_in;
      ocount_ff   <= ocount_in;
      dtotal_ff   <= dtotal_in;
      drop_ff     <= drop_in;
   end

   assign rsp_ch.valid            = (state_ff == ST_RESP);
   assign rsp_ch.found_before     = found_ff;
   assign rsp_ch.occurrence_count = ocount_ff;
   assign rsp_ch.distinct_total   = dtotal_ff;
   assign rsp_ch.dropped          = drop_ff;

endmodule

@@ tb/address_occurrence_counting_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the address occurrence counting table.
// A scoreboard class predicts every response from its own copy of the table.
// Depends on aoct_pkg, aoct_if and the address_occurrence_counting_table RTL.
module address_occurrence_counting_table_tb;

   localparam int ADDR_W      = aoct_pkg::ADDR_W;
   localparam int OUT_COUNT_W = aoct_pkg::OUT_COUNT_W;
   localparam int TOTAL_W     = aoct_pkg::TOTAL_W;
   localparam int BUCKETS    = aoct_pkg::BUCKETS_DEF;
   localparam int WAYS       = aoct_pkg::WAYS_DEF;
   localparam int COUNT_BITS = aoct_pkg::COUNT_BITS_DEF;
   localparam int SLOTS      = BUCKETS * WAYS;
   localparam longint unsigned HIT_COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned SHOWN_COUNT_MAX = (64'd1 << OUT_COUNT_W) - 1;
   localparam int unsigned DISTINCT_MAX = 2047;
   localparam int SETTLE_CYCLES = WAYS + 3;
   localparam int PINNED_HITS = 40;
   localparam longint unsigned CYCLE_LIMIT = 200_000;

   typedef struct packed {
      logic                   found_before;
      logic [OUT_COUNT_W-1:0] occurrence_count;
      logic [TOTAL_W-1:0]     distinct_total;
      logic                   dropped;
   } tally_type;

   class occurrence_scoreboard_type;
      bit                slot_used [SLOTS];
      bit [ADDR_W-1:0]   slot_addr [SLOTS];
      longint unsigned   slot_hits [SLOTS];
      int unsigned       distinct;
      bit                start_count;
      tally_type         awaited [$];
      int unsigned       errors;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         distinct    = 0;
         start_count = 1'b1;
         errors      = 0;
      endfunction

      function void set_start_count(bit value);
         start_count = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Applies one accepted address to the table copy and queues its response.
      function void note_address(logic [ADDR_W-1:0] address);
         int unsigned     base;
         int              way;
         int              free_way;
         longint unsigned shown;
         tally_type       t;
         base     = (address % BUCKETS) * WAYS;
         free_way = -1;
         shown    = 0;
         t        = '0;
         for (way = 0; way < WAYS; way++) begin
            if (slot_used[base + way]) begin
               if (slot_addr[base + way] == address) begin
                  if (slot_hits[base + way] < HIT_COUNT_MAX)
                     slot_hits[base + way]++;
                  shown          = slot_hits[base + way];
                  t.found_before = 1'b1;
                  break;
               end
            end else if (free_way < 0) begin
               free_way = way;
            end
         end
         if (!t.found_before) begin
            if (free_way >= 0) begin
               slot_used[base + free_way] = 1'b1;
               slot_addr[base + free_way] = address;
               slot_hits[base + free_way] = start_count & HIT_COUNT_MAX;
               shown = slot_hits[base + free_way];
               if (distinct < DISTINCT_MAX)
                  distinct++;
            end else begin
               t.dropped = 1'b1;
            end
         end
         if (shown > SHOWN_COUNT_MAX)
            shown = SHOWN_COUNT_MAX;
         t.occurrence_count = shown[OUT_COUNT_W-1:0];
         t.distinct_total   = distinct[TOTAL_W-1:0];
         awaited.push_back(t);
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got,
                  want);
      endtask

      task check_result(tally_type got);
         tally_type want;
         if (awaited.size() == 0) begin
            report_mismatch("response with no item outstanding", 1, 0);
            return;
         end
         want = awaited.pop_front();
         if (got.found_before !== want.found_before)
            report_mismatch("found_before", got.found_before, want.found_before);
         if (got.occurrence_count !== want.occurrence_count)
            report_mismatch("occurrence_count", got.occurrence_count,
                            want.occurrence_count);
         if (got.distinct_total !== want.distinct_total)
            report_mismatch("distinct_total", got.distinct_total, want.distinct_total);
         if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   bit   gaps_on = 1'b1;
   longint unsigned cycle_count = 0;
   logic [ADDR_W-1:0] seen_addresses [$];
   occurrence_scoreboard_type board;

   aoct_req_if req_ch ();
   aoct_rsp_if rsp_ch ();

   address_occurrence_counting_table #(
      .BUCKETS    (BUCKETS),
      .WAYS       (WAYS),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: checks each accepted item and stalls now and then.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_result({rsp_ch.found_before, rsp_ch.occurrence_count,
                                rsp_ch.distinct_total, rsp_ch.dropped});
         rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 11);
      end
   end

   // Offers one address, possibly after a short gap, and returns at its acceptance.
   task automatic send_address(input logic [ADDR_W-1:0] address);
      if (gaps_on && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.address <= address;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_address(address);
   endtask

   task automatic drain_table();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_count(input bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_start_count(value);
   endtask

   function automatic logic [ADDR_W-1:0] in_bucket(input logic [ADDR_W-1:0] raw,
                                                   input int unsigned bucket);
      return raw - (raw % BUCKETS) + (bucket % BUCKETS);
   endfunction

   // Mostly repeats and addresses crowded into a few buckets, so that hits,
   // fills and drops are all frequent.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned roll;
      int unsigned hot [8];
      hot  = '{8'h00, 8'h01, 8'h3C, 8'h5A, 8'h80, 8'hC3, 8'hFE, 8'hFF};
      roll = $urandom_range(99);
      if (roll < 40 && seen_addresses.size() > 0)
         return seen_addresses[$urandom_range(seen_addresses.size() - 1)];
      if (roll < 75)
         return in_bucket($urandom(), hot[$urandom_range(7)]);
      return $urandom();
   endfunction

   task automatic send_mixed(input int items);
      logic [ADDR_W-1:0] address;
      repeat (items) begin
         address = pick_address();
         seen_addresses.push_back(address);
         send_address(address);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] opening [14];
      logic [ADDR_W-1:0] zero_start [5];
      logic [ADDR_W-1:0] pinned;
      logic [ADDR_W-1:0] address;
      // Bucket 0 fills up and then drops; the extremes and alternating bit
      // patterns are mixed in.
      opening = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'h0000_0100, 32'h7FFF_FF00, 32'h0000_0200, 32'h7FFF_FF00,
                  32'h8000_0000, 32'h0000_0200, 32'hFFFF_FFFF, 32'h0000_00FF,
                  32'hAAAA_AAAA, 32'h5555_5555};
      zero_start = '{32'h1234_5678, 32'h1234_5678, 32'h0000_0300, 32'hFFFF_FF7F,
                     32'hFFFF_FF7F};
      pinned = 32'h5A5A_5A37;

      board = new();
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.address <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_start_count(1'b1);
      foreach (opening[i]) send_address(opening[i]);
      drain_table();
      write_start_count(1'b0);
      foreach (zero_start[i]) send_address(zero_start[i]);
      drain_table();

      // One address hit back to back many times, with no gaps on either side.
      write_start_count(1'b1);
      gaps_on = 1'b0;
      repeat (PINNED_HITS) send_address(pinned);
      drain_table();
      gaps_on = 1'b1;

      send_mixed(80);
      drain_table();

      // Every bucket gets four or five new addresses, which fills the table.
      write_start_count(1'b0);
      for (int unsigned b = 0; b < BUCKETS; b++) begin
         repeat ($urandom_range(4, 5)) begin
            address = in_bucket($urandom(), b);
            seen_addresses.push_back(address);
            send_address(address);
         end
      end
      drain_table();

      write_start_count(1'b1);
      send_mixed(60);
      drain_table();

      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
